@@ rtl/core/hppc_pkg.sv @@
// Shared types, constants and tables for the heading pursuit controller.
// No dependencies; every other file in rtl/core takes names from here.
package hppc_pkg;

  // CORDIC iteration count (8 to 24)
  localparam int CORDIC_ITERATIONS = 16;

  // Vector datapath widths
  localparam int ARG_W  = 34;   // atan2 operand width
  localparam int VEC_W  = 54;   // normalised vector width incl. CORDIC growth
  localparam int ANG_W  = 35;   // Q2.30 angle accumulator width
  localparam int OUT_W  = 16;   // Q3.13 angle width

  // Normalisation: binary search of the doubling count, then one last doubling
  localparam int NORM_STEPS = 6;
  localparam int NORM_EXP   = 48;

  // Pipeline depth of hppc_atan2, from atan2 operands to registered angle
  localparam int ATAN_LAT = NORM_STEPS + CORDIC_ITERATIONS + 2;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t PI_Q30     = 35'sd3373259426;
  localparam ang_t ANG_RND    = 35'sd65536;
  localparam ang_t PI_Q13_ANG = 35'sd25736;

  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  // Truncated arctangent table, Q2.30
  localparam ang_t ATAN_TAB [24] = '{
    35'sh03243F6A8, 35'sh01DAC6705, 35'sh00FADBAFC, 35'sh007F56EA6,
    35'sh003FEAB76, 35'sh001FFD55B, 35'sh000FFFAAA, 35'sh0007FFF55,
    35'sh0003FFFEA, 35'sh0001FFFFD, 35'sh0000FFFFF, 35'sh00007FFFF,
    35'sh00003FFFF, 35'sh00001FFFF, 35'sh00000FFFF, 35'sh000007FFF,
    35'sh000003FFF, 35'sh000001FFF, 35'sh000000FFF, 35'sh0000007FF,
    35'sh0000003FF, 35'sh0000001FF, 35'sh0000000FF, 35'sh00000007F
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_SPEED = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] GAIN_RESET  = 16'd640;
  localparam logic [15:0] SPEED_RESET = 16'd128;

  typedef struct packed {
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
    logic               path_empty;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               saturated;
  } cmd_t;

  // One element of the vector chain
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    ang_t                    z;
    logic                    zero;
  } vec_t;

  // Shift tried by normalisation step k: 32, 16, 8, 4, 2, 1
  function automatic logic [5:0] norm_shift(input int k);
    return 6'(32 >> k);
  endfunction

endpackage

@@ rtl/core/heading_pursuit_p_controller.sv @@
// Heading pursuit proportional controller, top level.
// Path from accepted pose to command: capture, products, the two atan2 chains,
// error, gain product and output registers; the atan2 chains make up most of it.
// Throughput: one transaction per cycle; a result stall freezes the pipeline.
// Reset (synchronous) clears all valid bits and loads register defaults.
module heading_pursuit_p_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            pose_valid,
  output logic            pose_stall,
  input  hppc_pkg::pose_t pose,
  output logic            cmd_valid,
  input  logic            cmd_stall,
  output hppc_pkg::cmd_t  cmd,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int L = hppc_pkg::ATAN_LAT;

  logic        mode;
  logic [15:0] gain;
  logic [15:0] speed;
  logic        en;

  logic            a_v;
  hppc_pkg::pose_t a;

  logic               b_v;
  logic signed [31:0] b_wz;
  logic signed [31:0] b_zz;
  logic signed [32:0] b_dx;
  logic signed [32:0] b_dy;
  logic signed [15:0] b_gh;
  logic               b_empty;

  logic signed [hppc_pkg::ARG_W-1:0] yaw_y;
  logic signed [hppc_pkg::ARG_W-1:0] yaw_x;
  logic signed [hppc_pkg::OUT_W-1:0] yaw;
  logic signed [hppc_pkg::OUT_W-1:0] bear;

  logic               sb_v     [L];
  logic signed [15:0] sb_gh    [L];
  logic               sb_empty [L];

  logic signed [17:0] tgt;
  logic signed [17:0] diff;
  logic               c_v;
  logic signed [17:0] c_err;
  logic               c_empty;

  logic               d_v;
  logic signed [34:0] d_prod;
  logic               d_empty;

  logic signed [34:0] rnd;
  logic signed [34:0] ang;
  hppc_pkg::cmd_t     cmd_next;

  // Whole pipeline advances unless the output holds a stalled result
  assign en         = !(cmd_valid && cmd_stall);
  assign pose_stall = !en;
  assign cfg_ready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      gain  <= hppc_pkg::GAIN_RESET;
      speed <= hppc_pkg::SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hppc_pkg::cfg_idx_t'(cfg_index))
        hppc_pkg::CFG_MODE:  mode  <= cfg_data[0];
        hppc_pkg::CFG_GAIN:  gain  <= cfg_data;
        hppc_pkg::CFG_SPEED: speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= pose_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= pose;
    end
  end

  // Quaternion products and goal offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_wz    <= a.quat_w * a.quat_z;
      b_zz    <= a.quat_z * a.quat_z;
      b_dx    <= 33'(a.goal_x) - 33'(a.pos_x);
      b_dy    <= 33'(a.goal_y) - 33'(a.pos_y);
      b_gh    <= a.goal_heading;
      b_empty <= a.path_empty;
    end
  end

  // Yaw vector: (1 - 2 qz^2, 2 qw qz) in Q2.30
  always_comb begin
    yaw_y = hppc_pkg::ARG_W'(b_wz) <<< 1;
    yaw_x = (hppc_pkg::ARG_W'(1) <<< 30) - (hppc_pkg::ARG_W'(b_zz) <<< 1);
  end

  hppc_atan2 u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (yaw_y),
    .x_in  (yaw_x),
    .angle (yaw)
  );

  hppc_atan2 u_bear (
    .clk   (clk),
    .en    (en),
    .y_in  (hppc_pkg::ARG_W'(b_dy)),
    .x_in  (hppc_pkg::ARG_W'(b_dx)),
    .angle (bear)
  );

  // Carry heading, empty flag and valid alongside the atan2 chains
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) begin
        sb_v[k] <= 1'b0;
      end
    end else if (en) begin
      sb_v[0] <= b_v;
      for (int k = 1; k < L; k++) begin
        sb_v[k] <= sb_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_gh[0]    <= b_gh;
      sb_empty[0] <= b_empty;
      for (int k = 1; k < L; k++) begin
        sb_gh[k]    <= sb_gh[k-1];
        sb_empty[k] <= sb_empty[k-1];
      end
    end
  end

  // Yaw error, wrapped once by 2 pi
  always_comb begin
    tgt  = mode ? 18'(bear) : 18'(sb_gh[L-1]);
    diff = tgt - 18'(yaw);
    if (diff > hppc_pkg::PI_Q13) begin
      diff = diff - hppc_pkg::TWO_PI_Q13;
    end else if (diff < -hppc_pkg::PI_Q13) begin
      diff = diff + hppc_pkg::TWO_PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      c_v <= sb_v[L-1];
      d_v <= c_v;
    end
  end

  // Gain product
  always_ff @(posedge clk) begin
    if (en) begin
      c_err   <= diff;
      c_empty <= sb_empty[L-1];
      d_prod  <= $signed({1'b0, gain}) * c_err;
      d_empty <= c_empty;
    end
  end

  // Round to Q8.8, saturate, zero an empty path
  always_comb begin
    rnd      = d_prod + 35'sd4096;
    ang      = rnd >>> 13;
    cmd_next.linear_cmd = speed;
    cmd_next.saturated  = 1'b0;
    if (ang > 35'sd32767) begin
      ang = 35'sd32767;
      cmd_next.saturated = 1'b1;
    end else if (ang < -35'sd32768) begin
      ang = -35'sd32768;
      cmd_next.saturated = 1'b1;
    end
    cmd_next.angular_cmd = ang[15:0];
    if (d_empty) begin
      cmd_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (en) begin
      cmd_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= cmd_next;
    end
  end

endmodule

@@ rtl/core/hppc_norm_cell.sv @@
// One step of the normalising shift search: double the vector by a fixed
// power of two when both components stay below the limit. Uses hppc_pkg.
module hppc_norm_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [5:0]         shift,
  input  hppc_pkg::vec_t     d,
  output hppc_pkg::vec_t     q
);

  logic signed [hppc_pkg::VEC_W-1:0] lim;
  logic                              fits;
  hppc_pkg::vec_t                    q_next;

  // Test both magnitudes against 2^(48 - shift)
  always_comb begin
    lim    = {{(hppc_pkg::VEC_W-1){1'b0}}, 1'b1} << (hppc_pkg::NORM_EXP - int'(shift));
    fits   = (d.x < lim) && (d.x > -lim) && (d.y < lim) && (d.y > -lim);
    q_next = d;
    if (fits) begin
      q_next.x = d.x <<< shift;
      q_next.y = d.y <<< shift;
    end
  end

  // Advance
  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ rtl/core/hppc_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with floor shifts. Uses hppc_pkg.
// Stage index and arctangent step arrive as constant ports.
module hppc_cordic_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [4:0]         idx,
  input  hppc_pkg::ang_t     step,
  input  hppc_pkg::vec_t     d,
  output hppc_pkg::vec_t     q
);

  logic signed [hppc_pkg::VEC_W-1:0] xs;
  logic signed [hppc_pkg::VEC_W-1:0] ys;
  hppc_pkg::vec_t                    q_next;

  // Rotate toward the x axis
  always_comb begin
    xs     = d.x >>> idx;
    ys     = d.y >>> idx;
    q_next = d;
    if (d.y >= 0) begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + step;
    end else begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ rtl/core/hppc_atan2.sv @@
// Pipelined atan2 in Q3.13: normalising cells, half-plane fold, CORDIC
// cells, rounding. Uses hppc_pkg, hppc_norm_cell and hppc_cordic_cell.
module hppc_atan2 (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hppc_pkg::ARG_W-1:0] y_in,
  input  logic signed [hppc_pkg::ARG_W-1:0] x_in,
  output logic signed [hppc_pkg::OUT_W-1:0] angle
);

  hppc_pkg::vec_t nrm [hppc_pkg::NORM_STEPS+1];
  hppc_pkg::vec_t cor [hppc_pkg::CORDIC_ITERATIONS+1];
  hppc_pkg::vec_t fold_next;
  logic signed [hppc_pkg::VEC_W-1:0] x2;
  logic signed [hppc_pkg::VEC_W-1:0] y2;
  hppc_pkg::ang_t zr;
  hppc_pkg::ang_t r;

  // Widen the operands into the chain
  always_comb begin
    nrm[0].x    = hppc_pkg::VEC_W'(x_in);
    nrm[0].y    = hppc_pkg::VEC_W'(y_in);
    nrm[0].z    = '0;
    nrm[0].zero = (x_in == '0) && (y_in == '0);
  end

  for (genvar k = 0; k < hppc_pkg::NORM_STEPS; k++) begin : g_norm
    hppc_norm_cell u_cell (
      .clk   (clk),
      .en    (en),
      .shift (hppc_pkg::norm_shift(k)),
      .d     (nrm[k]),
      .q     (nrm[k+1])
    );
  end

  // Last doubling, then fold the left half-plane onto the right
  always_comb begin
    x2        = nrm[hppc_pkg::NORM_STEPS].x <<< 1;
    y2        = nrm[hppc_pkg::NORM_STEPS].y <<< 1;
    fold_next = nrm[hppc_pkg::NORM_STEPS];
    fold_next.x = x2;
    fold_next.y = y2;
    fold_next.z = '0;
    if (x2 < 0) begin
      fold_next.x = -x2;
      fold_next.y = -y2;
      fold_next.z = (y2 >= 0) ? hppc_pkg::PI_Q30 : -hppc_pkg::PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor[0] <= fold_next;
    end
  end

  for (genvar i = 0; i < hppc_pkg::CORDIC_ITERATIONS; i++) begin : g_cordic
    hppc_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .idx  (5'(i)),
      .step (hppc_pkg::ATAN_TAB[i]),
      .d    (cor[i]),
      .q    (cor[i+1])
    );
  end

  // Round to Q3.13 and clamp to +-pi; a zero vector gives zero
  always_comb begin
    zr = cor[hppc_pkg::CORDIC_ITERATIONS].z + hppc_pkg::ANG_RND;
    r  = zr >>> 17;
    if (r > hppc_pkg::PI_Q13_ANG) begin
      r = hppc_pkg::PI_Q13_ANG;
    end else if (r < -hppc_pkg::PI_Q13_ANG) begin
      r = -hppc_pkg::PI_Q13_ANG;
    end
    if (cor[hppc_pkg::CORDIC_ITERATIONS].zero) begin
      r = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= r[hppc_pkg::OUT_W-1:0];
    end
  end

endmodule
